FILE: hw/rtl/fsbc_pkg.sv
// Package for the frame sync byte capture block: register map, match state
// constants and the result record. No dependencies.
`timescale 1ns / 1ps

package fsbc_pkg;

	// Byte buffer that receives the captured bytes lies outside the block.
	localparam int unsigned BufferDepth = 32768;
	localparam int unsigned AddrSpan    = 32768;
	localparam int unsigned AddrW       = 15;
	localparam int unsigned LimitW      = 16;
	localparam int unsigned CapValue    = (BufferDepth < AddrSpan) ? BufferDepth : AddrSpan;
	localparam logic [LimitW-1:0] BufferCap = LimitW'(CapValue);

	// APB register map, one 32-bit register every four bytes.
	localparam int unsigned PaddrW = 5;
	localparam int unsigned RegIdxW = 3;
	typedef enum logic [RegIdxW-1:0] {
		REG_HEADER_FIRST   = 3'd0,
		REG_HEADER_SECOND  = 3'd1,
		REG_TRAILER_FIRST  = 3'd2,
		REG_TRAILER_SECOND = 3'd3,
		REG_LENGTH_LIMIT   = 3'd4
	} reg_idx_t;

	localparam logic [7:0]        HeaderFirstRst   = 8'h43;
	localparam logic [7:0]        HeaderSecondRst  = 8'hC6;
	localparam logic [7:0]        TrailerFirstRst  = 8'hC5;
	localparam logic [7:0]        TrailerSecondRst = 8'hDB;
	localparam logic [LimitW-1:0] LengthLimitRst   = 16'd24576;

	// Match progress: 0..5 header pairs, 6 capturing, 7..11 trailer pairs.
	typedef logic [3:0] match_t;
	localparam match_t MatchHunt     = 4'd0;
	localparam match_t PayloadStart  = 4'd6;
	localparam match_t TrailerLast   = 4'd11;

	typedef struct packed {
		logic             store_enable;
		logic [AddrW-1:0] store_address;
		logic [7:0]       store_data;
		logic             frame_done;
		logic             ended_by_limit;
		logic             in_payload;
	} cap_result_t;

endpackage

FILE: hw/rtl/fsbc_rx_if.sv
// Byte input channel of the frame sync byte capture block.
// Depends on nothing but the valid/ready convention.
`timescale 1ns / 1ps

interface fsbc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/fsbc_cap_if.sv
// Result channel of the frame sync byte capture block.
// Depends on fsbc_pkg for the address width.
`timescale 1ns / 1ps

interface fsbc_cap_if;
	logic                       valid;
	logic                       ready;
	logic                       store_enable;
	logic [fsbc_pkg::AddrW-1:0] store_address;
	logic [7:0]                 store_data;
	logic                       frame_done;
	logic                       ended_by_limit;
	logic                       in_payload;

	modport source (output valid, input ready, output store_enable, output store_address,
		output store_data, output frame_done, output ended_by_limit, output in_payload);
	modport sink (input valid, output ready, input store_enable, input store_address,
		input store_data, input frame_done, input ended_by_limit, input in_payload);
endinterface

FILE: hw/rtl/frame_sync_byte_capture_top.sv
// Top level of the frame sync byte capture block.
// Depends on fsbc_pkg, fsbc_rx_if and fsbc_cap_if.
`timescale 1ns / 1ps

// Usage:
// Received bytes enter on the rx channel, one transaction per byte. For every
// byte the block returns exactly one transaction on the cap channel. While the
// block hunts for the header (three pairs of the header bytes) the result only
// reports progress through in_payload. Once the header is found, every byte,
// trailer bytes included, is reported with store_enable high, its buffer
// address and its value, so the caller can write it into an external buffer.
// The frame ends when three trailer pairs complete or the byte count reaches
// the length limit (capped at the buffer size); frame_done marks that byte and
// ended_by_limit tells which way it ended.
// Timing: the whole decision is one compare and one increment, done as the
// byte is accepted; the result is registered, and a new byte is taken every
// cycle while the skid register is empty. An output register plus a skid
// register decouple the channels: a stalled receiver fills the skid register,
// and rx.ready drops only while that register is occupied.
// Reset clears the match state and the byte count, empties both result
// registers and loads the default register values. Registers are written over
// APB at byte address 4*i and must only be written while no transaction is in flight.
module frame_sync_byte_capture_top (
	input  logic                          clk,
	input  logic                          arst_n,
	fsbc_rx_if.sink                       rx,
	fsbc_cap_if.source                    cap,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fsbc_pkg::PaddrW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// Configuration registers.
	logic [7:0]                    header_first_q;
	logic [7:0]                    header_second_q;
	logic [7:0]                    trailer_first_q;
	logic [7:0]                    trailer_second_q;
	logic [fsbc_pkg::LimitW-1:0]   length_limit_q;

	// Frame tracking state.
	fsbc_pkg::match_t              match_q;
	logic [fsbc_pkg::AddrW-1:0]    count_q;

	// Output register and skid register.
	fsbc_pkg::cap_result_t         out_q;
	logic                          out_valid_q;
	fsbc_pkg::cap_result_t         skid_q;
	logic                          skid_valid_q;

	logic                          cfg_write;
	fsbc_pkg::reg_idx_t            cfg_idx;
	logic                          rx_accept;
	logic                          out_free;

	fsbc_pkg::match_t              match_d;
	logic [fsbc_pkg::AddrW-1:0]    count_d;
	fsbc_pkg::cap_result_t         result;
	logic [fsbc_pkg::LimitW-1:0]   cap_limit;
	logic [fsbc_pkg::LimitW-1:0]   next_count;
	logic [7:0]                    want;

	// ------------------------------------------------------------------
	// APB register file. A write lands in the access phase; pready is tied
	// high so every transfer completes without wait states.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx   = fsbc_pkg::reg_idx_t'(paddr[fsbc_pkg::PaddrW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q   <= fsbc_pkg::HeaderFirstRst;
			header_second_q  <= fsbc_pkg::HeaderSecondRst;
			trailer_first_q  <= fsbc_pkg::TrailerFirstRst;
			trailer_second_q <= fsbc_pkg::TrailerSecondRst;
			length_limit_q   <= fsbc_pkg::LengthLimitRst;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				fsbc_pkg::REG_HEADER_FIRST:   header_first_q   <= pwdata[7:0];
				fsbc_pkg::REG_HEADER_SECOND:  header_second_q  <= pwdata[7:0];
				fsbc_pkg::REG_TRAILER_FIRST:  trailer_first_q  <= pwdata[7:0];
				fsbc_pkg::REG_TRAILER_SECOND: trailer_second_q <= pwdata[7:0];
				fsbc_pkg::REG_LENGTH_LIMIT:   length_limit_q   <= pwdata[fsbc_pkg::LimitW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			fsbc_pkg::REG_HEADER_FIRST:   prdata = {24'd0, header_first_q};
			fsbc_pkg::REG_HEADER_SECOND:  prdata = {24'd0, header_second_q};
			fsbc_pkg::REG_TRAILER_FIRST:  prdata = {24'd0, trailer_first_q};
			fsbc_pkg::REG_TRAILER_SECOND: prdata = {24'd0, trailer_second_q};
			fsbc_pkg::REG_LENGTH_LIMIT:   prdata = {16'd0, length_limit_q};
			default:                      prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Match logic for one byte. The frame ends when the count would reach
	// the smaller of the length limit and the buffer size; a limit hit wins
	// over a trailer completing on the same byte.
	// ------------------------------------------------------------------
	assign cap_limit  = (length_limit_q < fsbc_pkg::BufferCap) ? length_limit_q
		: fsbc_pkg::BufferCap;
	assign next_count = fsbc_pkg::LimitW'(count_q) + 1'b1;

	always_comb begin
		match_d = match_q;
		count_d = count_q;
		result  = '0;
		want    = 8'd0;
		if (match_q >= fsbc_pkg::PayloadStart) begin
			result.store_enable  = 1'b1;
			result.store_address = count_q;
			result.store_data    = rx.rx_byte;
			if (next_count >= cap_limit) begin
				result.frame_done     = 1'b1;
				result.ended_by_limit = 1'b1;
				count_d = '0;
				match_d = fsbc_pkg::MatchHunt;
			end else begin
				count_d = next_count[fsbc_pkg::AddrW-1:0];
				// Odd states wait for the second trailer byte, even states the first.
				want = match_q[0] ? trailer_second_q : trailer_first_q;
				if (match_q == fsbc_pkg::PayloadStart) begin
					if (rx.rx_byte == want) begin
						match_d = match_q + 1'b1;
					end
				end else if (rx.rx_byte != want) begin
					// Drop back to waiting for the first trailer byte, this one is not rechecked.
					match_d = fsbc_pkg::PayloadStart;
				end else if (match_q >= fsbc_pkg::TrailerLast) begin
					result.frame_done = 1'b1;
					count_d = '0;
					match_d = fsbc_pkg::MatchHunt;
				end else begin
					match_d = match_q + 1'b1;
				end
			end
		end else begin
			want = match_q[0] ? header_second_q : header_first_q;
			match_d = (rx.rx_byte == want) ? match_q + 1'b1 : fsbc_pkg::MatchHunt;
		end
		result.in_payload = (match_d >= fsbc_pkg::PayloadStart);
	end

	// ------------------------------------------------------------------
	// Channel control. The state advances on every accepted byte.
	// ------------------------------------------------------------------
	assign rx.ready  = !skid_valid_q;
	assign rx_accept = rx.valid && !skid_valid_q;
	assign out_free  = !out_valid_q || cap.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= fsbc_pkg::MatchHunt;
			count_q <= '0;
		end else if (rx_accept) begin
			match_q <= match_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || rx_accept;
				skid_valid_q <= 1'b0;
			end else if (rx_accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : result;
		end
		if (!out_free && rx_accept) begin
			skid_q <= result;
		end
	end

	assign cap.valid          = out_valid_q;
	assign cap.store_enable   = out_q.store_enable;
	assign cap.store_address  = out_q.store_address;
	assign cap.store_data     = out_q.store_data;
	assign cap.frame_done     = out_q.frame_done;
	assign cap.ended_by_limit = out_q.ended_by_limit;
	assign cap.in_payload     = out_q.in_payload;

endmodule

FILE: test/fsbc_capture_checker.sv
// Checker for the frame sync byte capture block: predicts every result from the
// accepted bytes and snooped APB writes, and compares it with the cap channel.
// Depends on fsbc_pkg, fsbc_rx_if and fsbc_cap_if.
`timescale 1ns / 1ps

module fsbc_capture_checker
	import fsbc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	fsbc_rx_if                rx,
	fsbc_cap_if               cap,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [PaddrW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output int                fail_count,
	output int                results_pending,
	output int                frames_ended,
	output int                limit_ends,
	output int                bytes_stored
);

	localparam int MaxReports = 10;

	// Shadow copy of the registers.
	logic [7:0]        hdr_first, hdr_second, trl_first, trl_second;
	logic [LimitW-1:0] frame_limit;

	// Predicted block state.
	match_t           sync_state;
	logic [AddrW-1:0] frame_bytes;

	cap_result_t expected_results[$];

	// Advances the predicted state by one received byte and returns its result.
	function automatic cap_result_t capture_next(input logic [7:0] b);
		cap_result_t       r;
		logic [LimitW-1:0] next_count;
		logic [LimitW-1:0] frame_cap;
		logic [7:0]        want;
		r = '0;
		frame_cap = (frame_limit < BufferCap) ? frame_limit : BufferCap;
		if (sync_state >= PayloadStart) begin
			next_count = LimitW'(frame_bytes) + 1'b1;
			r.store_enable  = 1'b1;
			r.store_address = frame_bytes;
			r.store_data    = b;
			if (next_count >= frame_cap) begin
				// The length limit takes precedence over a completing trailer.
				r.frame_done     = 1'b1;
				r.ended_by_limit = 1'b1;
				frame_bytes = '0;
				sync_state  = MatchHunt;
			end else begin
				frame_bytes = next_count[AddrW-1:0];
				if (sync_state == PayloadStart) begin
					if (b == trl_first)
						sync_state = sync_state + 1'b1;
				end else begin
					want = sync_state[0] ? trl_second : trl_first;
					if (b != want) begin
						sync_state = PayloadStart;
					end else if (sync_state >= TrailerLast) begin
						r.frame_done = 1'b1;
						frame_bytes = '0;
						sync_state  = MatchHunt;
					end else begin
						sync_state = sync_state + 1'b1;
					end
				end
			end
		end else begin
			want = sync_state[0] ? hdr_second : hdr_first;
			sync_state = (b == want) ? match_t'(sync_state + 1'b1) : MatchHunt;
		end
		r.in_payload = (sync_state >= PayloadStart);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input cap_result_t exp_r,
			input cap_result_t got_r);
		fail_count++;
		if (fail_count <= MaxReports) begin
			$display("%s: expected en=%0b addr=%0d data=%02h done=%0b lim=%0b pay=%0b",
				what, exp_r.store_enable, exp_r.store_address, exp_r.store_data,
				exp_r.frame_done, exp_r.ended_by_limit, exp_r.in_payload);
			$display("%s: got      en=%0b addr=%0d data=%02h done=%0b lim=%0b pay=%0b",
				what, got_r.store_enable, got_r.store_address, got_r.store_data,
				got_r.frame_done, got_r.ended_by_limit, got_r.in_payload);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		cap_result_t exp_r;
		cap_result_t got_r;
		if (!arst_n) begin
			hdr_first   = HeaderFirstRst;
			hdr_second  = HeaderSecondRst;
			trl_first   = TrailerFirstRst;
			trl_second  = TrailerSecondRst;
			frame_limit = LengthLimitRst;
			sync_state  = MatchHunt;
			frame_bytes = '0;
			expected_results.delete();
			fail_count      = 0;
			results_pending = 0;
			frames_ended    = 0;
			limit_ends      = 0;
			bytes_stored    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PaddrW-1:2])
					REG_HEADER_FIRST:   hdr_first   = pwdata[7:0];
					REG_HEADER_SECOND:  hdr_second  = pwdata[7:0];
					REG_TRAILER_FIRST:  trl_first   = pwdata[7:0];
					REG_TRAILER_SECOND: trl_second  = pwdata[7:0];
					REG_LENGTH_LIMIT:   frame_limit = pwdata[LimitW-1:0];
					default: ;
				endcase
			end
			if (rx.valid && rx.ready) begin
				exp_r = capture_next(rx.rx_byte);
				expected_results.push_back(exp_r);
				bytes_stored += exp_r.store_enable;
				frames_ended += exp_r.frame_done;
				limit_ends   += exp_r.ended_by_limit;
			end
			if (cap.valid && cap.ready) begin
				got_r.store_enable   = cap.store_enable;
				got_r.store_address  = cap.store_address;
				got_r.store_data     = cap.store_data;
				got_r.frame_done     = cap.frame_done;
				got_r.ended_by_limit = cap.ended_by_limit;
				got_r.in_payload     = cap.in_payload;
				if (expected_results.size() == 0) begin
					report_mismatch("Unexpected result", '0, got_r);
				end else begin
					exp_r = expected_results.pop_front();
					if (got_r !== exp_r)
						report_mismatch("Result mismatch", exp_r, got_r);
				end
			end
			results_pending = expected_results.size();
		end
	end

endmodule

FILE: test/tb_frame_sync_byte_capture_top.sv
// Testbench top for the frame sync byte capture block: clock, reset, byte
// stimulus, APB register phases, result-side stalls, watchdog and verdict.
// Depends on fsbc_pkg, the two channel interfaces and fsbc_capture_checker.
`timescale 1ns / 1ps

module tb_frame_sync_byte_capture_top;
	import fsbc_pkg::*;

	// Register index that is not mapped; writes to it must be ignored.
	localparam logic [RegIdxW-1:0] RegUnmapped = 3'd5;
	// Cycles without any transaction before the run is declared hung.
	localparam int StallLimit  = 2000;
	// Extra cycles allowed after the last result before touching registers.
	localparam int DrainCycles = 4;
	localparam int IdlePercent = 29;
	localparam int TotalBytes  = 1200;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [PaddrW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// When low, neither side inserts idle cycles.
	logic gaps_on;

	// Shadow of the current register values, used only to shape the stimulus
	// so that most frames carry well-formed headers and trailers.
	logic [7:0]        hf, hs, tf, ts;

	int bytes_sent;
	int settings_applied;
	int stall_cycles;

	int fail_count, results_pending, frames_ended, limit_ends, bytes_stored;

	fsbc_rx_if  rx_ch ();
	fsbc_cap_if cap_ch ();

	frame_sync_byte_capture_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.cap     (cap_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	fsbc_capture_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx              (rx_ch),
		.cap             (cap_ch),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.fail_count      (fail_count),
		.results_pending (results_pending),
		.frames_ended    (frames_ended),
		.limit_ends      (limit_ends),
		.bytes_stored    (bytes_stored)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The result side stalls at random; all changes happen on the falling edge
	// so that the block sees stable inputs at every rising edge.
	initial begin
		cap_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cap_ch.ready <= !gaps_on || ($urandom_range(99) >= IdlePercent);
		end
	end

	// Watchdog: any transaction on either channel restarts the count. A hang
	// anywhere, including results that never arrive, ends the run here.
	always @(posedge clk) begin
		if (stall_cycles >= StallLimit) begin
			$display("Watchdog: %0d cycles without a transaction, %0d results still due",
				stall_cycles, results_pending);
			$display("FAILED: results differ");
			$finish;
		end
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (cap_ch.valid && cap_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	// Offers one byte and returns at the falling edge after it was accepted.
	// Valid is only ever lowered here or in settle_block, so it never gets two
	// assignments at the same edge.
	task automatic send_byte(input logic [7:0] b);
		while (gaps_on && $urandom_range(99) < IdlePercent) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Sends n bytes alternating between the two bytes of a pair pattern.
	task automatic send_pairs(input logic [7:0] first, input logic [7:0] second,
			input int n);
		for (int i = 0; i < n; i++)
			send_byte(i[0] ? second : first);
	endtask

	// Sends the first cut bytes of a pair pattern and then one byte that
	// cannot match the next expected byte.
	task automatic send_broken_pairs(input logic [7:0] first, input logic [7:0] second,
			input int cut);
		logic [7:0] wrong;
		send_pairs(first, second, cut);
		wrong = (cut % 2 == 1) ? second : first;
		wrong = wrong ^ 8'($urandom_range(1, 255));
		send_byte(wrong);
	endtask

	// Stops sending and waits until every predicted result has come back,
	// then lets the block settle for a few more cycles.
	task automatic settle_block();
		rx_ch.valid <= 1'b0;
		do @(negedge clk); while (results_pending != 0);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle; an idle gap follows so that
	// back-to-back writes never assign psel twice at the same edge.
	task automatic reg_write(input logic [RegIdxW-1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Writes all five registers while the block is idle. The length word may
	// carry junk above bit 15 to show that the register keeps only 16 bits.
	task automatic apply_settings(input logic [7:0] h1, input logic [7:0] h2,
			input logic [7:0] t1, input logic [7:0] t2, input logic [31:0] lim_word);
		settle_block();
		reg_write(REG_HEADER_FIRST, {24'($urandom), h1});
		reg_write(REG_HEADER_SECOND, {24'($urandom), h2});
		reg_write(REG_TRAILER_FIRST, {24'($urandom), t1});
		reg_write(REG_TRAILER_SECOND, {24'($urandom), t2});
		reg_write(REG_LENGTH_LIMIT, lim_word);
		hf  = h1;
		hs  = h2;
		tf  = t1;
		ts  = t2;
		settings_applied++;
	endtask

	// One random frame: optional line noise, a header that is usually whole,
	// a payload of random length sprinkled with trailer-start bytes, and a
	// trailer that is usually whole. Broken headers and trailers stop early at
	// a random position with a byte that cannot match.
	task automatic send_frame();
		int cut;
		int body;
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
		cut = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : 6;
		if (cut < 6) begin
			send_broken_pairs(hf, hs, cut);
			return;
		end
		send_pairs(hf, hs, 6);
		body = $urandom_range(0, 20);
		repeat (body) send_byte(($urandom_range(9) == 0) ? tf : 8'($urandom));
		cut = ($urandom_range(4) == 0) ? $urandom_range(0, 5) : 6;
		if (cut < 6)
			send_broken_pairs(tf, ts, cut);
		else
			send_pairs(tf, ts, 6);
	endtask

	task automatic frames_until(input int target);
		while (bytes_sent < target)
			send_frame();
	endtask

	initial begin
		arst_n        = 1'b0;
		gaps_on       = 1'b1;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		hf            = HeaderFirstRst;
		hs            = HeaderSecondRst;
		tf            = TrailerFirstRst;
		ts            = TrailerSecondRst;
		bytes_sent       = 0;
		settings_applied = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part under the reset register values. A header broken by a
		// repeated first byte must restart the hunt without counting that byte
		// as a new start; likewise a trailer broken by a repeated first byte
		// falls back to plain capture without rechecking it.
		send_broken_pairs(hf, hs, 3);
		send_pairs(hf, hs, 3);
		send_byte(hf);
		send_pairs(hf, hs, 6);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_pairs(tf, ts, 3);
		send_byte(tf);
		send_pairs(tf, ts, 6);

		// A limit of six lets a trailer that starts the payload complete on
		// the very byte that reaches the limit; the limit has to win.
		apply_settings(hf, hs, tf, ts, 32'd6);
		send_pairs(hf, hs, 6);
		send_pairs(tf, ts, 6);
		frames_until(180);

		// Extreme byte patterns and an all-ones length word, which the buffer
		// size caps. This phase runs with no idle cycles on either side.
		apply_settings(8'h00, 8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFF);
		gaps_on = 1'b0;
		frames_until(300);
		// Sender holds off until every outstanding result has drained.
		settle_block();
		frames_until(420);
		gaps_on = 1'b1;

		// Zero limit: every captured byte ends its frame.
		apply_settings(hf, hs, tf, ts, 32'd0);
		frames_until(500);

		// Smallest legal limit, and a write to an unmapped register index.
		apply_settings(8'h5A, 8'hA5, 8'h3C, 8'hC3, 32'd1);
		reg_write(RegUnmapped, $urandom);
		frames_until(580);

		// Largest legal limit.
		apply_settings(8'hFF, 8'h00, 8'h00, 8'hFF, 32'd32768);
		frames_until(680);

		// Random settings with short limits so that both ways of ending a
		// frame keep occurring.
		while (bytes_sent < TotalBytes) begin
			apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				{16'($urandom), 16'($urandom_range(2, 40))});
			frames_until(bytes_sent + 100);
		end

		settle_block();

		$display("Sent %0d bytes under %0d register settings besides reset.",
			bytes_sent, settings_applied);
		$display("Predicted %0d stored bytes and %0d frame ends, %0d of them by length limit.",
			bytes_stored, frames_ended, limit_ends);
		if (fail_count == 0 && results_pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d failures, %0d results still due", fail_count, results_pending);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
